// ===== design/voxel_grid_scroll_shift_defines.svh =====
// Assertion macros shared by the voxel grid scroll block.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef VOXEL_GRID_SCROLL_SHIFT_DEFINES_SVH
`define VOXEL_GRID_SCROLL_SHIFT_DEFINES_SVH

// same-cycle implication
`define VGSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VGSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/vgss_pkg.sv =====
// Shared codes, field widths and control/status types for the voxel grid
// scroll block. No dependencies.
package vgss_pkg;

    localparam int REQ_W   = 2;
    localparam int CELL_W  = 15;
    localparam int SHIFT_W = 7;

    localparam logic [REQ_W-1:0] REQ_WRITE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SCROLL = 2'd2;

    // sweep phase: reset clear, then one per axis
    localparam logic [1:0] PH_CLEAR = 2'd0;
    localparam logic [1:0] PH_X     = 2'd1;
    localparam logic [1:0] PH_Y     = 2'd2;
    localparam logic [1:0] PH_Z     = 2'd3;

    typedef struct packed {
        logic       load;
        logic       write_item;
        logic       read_item;
        logic       init;
        logic       step;
        logic [1:0] phase;
        logic       res_read;
        logic       res_zero;
        logic       res_regen;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic n_zero;
    } sts_t;

endpackage

// ===== design/vgss_req_if.sv =====
// Request channel: valid/ready handshake with the request fields.
// Depends on vgss_pkg.
interface vgss_req_if;
    logic                                valid;
    logic                                ready;
    logic [vgss_pkg::REQ_W-1:0]          req_type;
    logic [vgss_pkg::CELL_W-1:0]         cell_index;
    logic                                loaded_in;
    logic                                solid_in;
    logic signed [vgss_pkg::SHIFT_W-1:0] shift_x;
    logic signed [vgss_pkg::SHIFT_W-1:0] shift_y;
    logic signed [vgss_pkg::SHIFT_W-1:0] shift_z;

    modport source (
        output valid, req_type, cell_index, loaded_in, solid_in, shift_x, shift_y, shift_z,
        input  ready
    );
    modport sink (
        input  valid, req_type, cell_index, loaded_in, solid_in, shift_x, shift_y, shift_z,
        output ready
    );
endinterface

// ===== design/vgss_rsp_if.sv =====
// Response channel: valid/ready handshake with the result fields.
// No dependencies.
interface vgss_rsp_if;
    logic valid;
    logic ready;
    logic loaded_out;
    logic solid_out;
    logic regen_needed;

    modport source (
        output valid, loaded_out, solid_out, regen_needed,
        input  ready
    );
    modport sink (
        input  valid, loaded_out, solid_out, regen_needed,
        output ready
    );
endinterface

// ===== design/vgss_datapath.sv =====
// Datapath: grid memory, sweep counters, copy pipeline and result register.
// Driven by vgss_ctrl through vgss_pkg::cmd_t; depends on vgss_pkg.
module vgss_datapath #(
    parameter int GRID_SIDE = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  vgss_pkg::cmd_t                      cmd,
    output vgss_pkg::sts_t                      sts,
    input  logic [vgss_pkg::CELL_W-1:0]         cell_index,
    input  logic                                loaded_in,
    input  logic                                solid_in,
    input  logic signed [vgss_pkg::SHIFT_W-1:0] shift_x,
    input  logic signed [vgss_pkg::SHIFT_W-1:0] shift_y,
    input  logic signed [vgss_pkg::SHIFT_W-1:0] shift_z,
    output logic                                loaded_out,
    output logic                                solid_out,
    output logic                                regen_needed
);

    localparam int CELLS = GRID_SIDE * GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(GRID_SIDE);
    localparam int NW    = $clog2(GRID_SIDE + 1);

    localparam logic [AW-1:0] IDX_LAST  = AW'(CELLS - 1);
    localparam logic [CW-1:0] COORD_TOP = CW'(GRID_SIDE - 1);

    function automatic logic [NW-1:0] sat_mag(input logic signed [vgss_pkg::SHIFT_W-1:0] v);
        int m;
        m = int'(v);
        if (m < 0)
        begin
            m = -m;
        end
        if (m > GRID_SIDE)
        begin
            m = GRID_SIDE;
        end
        return NW'(m);
    endfunction

    logic [1:0] grid_mem [CELLS];
    logic [1:0] rd_data_reg;

    logic [AW-1:0] idx_reg, idx_next;
    logic [CW-1:0] xc_reg, xc_next, yc_reg, yc_next, zc_reg, zc_next;
    logic          wr_valid_reg, wr_valid_next;
    logic [AW-1:0] wr_addr_reg;
    logic          wr_zero_reg;
    logic [NW-1:0] n_reg [3];
    logic          neg_reg [3];
    logic [AW:0]   amt_reg;
    logic          rd_ok_reg;
    logic          loaded_reg, solid_reg, regen_reg;

    logic          desc;
    logic [NW-1:0] n_cur;
    logic          neg_cur;
    logic [CW-1:0] a_cur;
    logic [NW:0]   a_ext, n_ext;
    logic          copy_ok;
    logic [AW:0]   src_wide;
    logic [AW:0]   amt_next;
    logic          in_range;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [1:0]    mem_wdata;

    always_comb
    begin
        unique case (cmd.phase)
            vgss_pkg::PH_X:
            begin
                n_cur   = n_reg[0];
                neg_cur = neg_reg[0];
                a_cur   = xc_reg;
                amt_next = (AW+1)'(int'(n_reg[0]));
            end
            vgss_pkg::PH_Y:
            begin
                n_cur   = n_reg[1];
                neg_cur = neg_reg[1];
                a_cur   = yc_reg;
                amt_next = (AW+1)'(int'(n_reg[1]) * GRID_SIDE);
            end
            vgss_pkg::PH_Z:
            begin
                n_cur   = n_reg[2];
                neg_cur = neg_reg[2];
                a_cur   = zc_reg;
                amt_next = (AW+1)'(int'(n_reg[2]) * GRID_SIDE * GRID_SIDE);
            end
            default:
            begin
                n_cur   = '0;
                neg_cur = 1'b1;
                a_cur   = xc_reg;
                amt_next = '0;
            end
        endcase
    end

    // positive offset walks downward so sources are read before overwrite
    assign desc  = (cmd.phase != vgss_pkg::PH_CLEAR) && !neg_cur;
    assign a_ext = (NW+1)'(a_cur);
    assign n_ext = (NW+1)'(n_cur);

    always_comb
    begin
        if (cmd.phase == vgss_pkg::PH_CLEAR)
        begin
            copy_ok = 1'b0;
        end
        else if (desc)
        begin
            copy_ok = (a_ext >= n_ext);
        end
        else
        begin
            copy_ok = ((a_ext + n_ext) < (NW+1)'(GRID_SIDE));
        end
    end

    assign src_wide = desc ? ((AW+1)'(idx_reg) - amt_reg) : ((AW+1)'(idx_reg) + amt_reg);
    assign in_range = (32'(cell_index) < 32'(CELLS));

    assign sts.last   = desc ? (idx_reg == '0) : (idx_reg == IDX_LAST);
    assign sts.n_zero = (n_cur == '0);

    // sweep counters
    always_comb
    begin
        idx_next = idx_reg;
        xc_next  = xc_reg;
        yc_next  = yc_reg;
        zc_next  = zc_reg;
        if (cmd.init)
        begin
            idx_next = desc ? IDX_LAST : '0;
            xc_next  = desc ? COORD_TOP : '0;
            yc_next  = desc ? COORD_TOP : '0;
            zc_next  = desc ? COORD_TOP : '0;
        end
        else if (cmd.step)
        begin
            if (desc)
            begin
                idx_next = idx_reg - AW'(1);
                if (xc_reg == '0)
                begin
                    xc_next = COORD_TOP;
                    if (yc_reg == '0)
                    begin
                        yc_next = COORD_TOP;
                        zc_next = zc_reg - CW'(1);
                    end
                    else
                    begin
                        yc_next = yc_reg - CW'(1);
                    end
                end
                else
                begin
                    xc_next = xc_reg - CW'(1);
                end
            end
            else
            begin
                idx_next = idx_reg + AW'(1);
                if (xc_reg == COORD_TOP)
                begin
                    xc_next = '0;
                    if (yc_reg == COORD_TOP)
                    begin
                        yc_next = '0;
                        zc_next = zc_reg + CW'(1);
                    end
                    else
                    begin
                        yc_next = yc_reg + CW'(1);
                    end
                end
                else
                begin
                    xc_next = xc_reg + CW'(1);
                end
            end
        end
    end

    assign wr_valid_next = cmd.step;

    // memory port muxing
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wr_addr_reg;
        mem_wdata = wr_zero_reg ? 2'b00 : rd_data_reg;
        if (wr_valid_reg)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.write_item && in_range)
        begin
            mem_we    = 1'b1;
            mem_waddr = AW'(cell_index);
            mem_wdata = {solid_in, loaded_in};
        end
        mem_re    = 1'b0;
        mem_raddr = AW'(src_wide);
        if (cmd.step && copy_ok)
        begin
            mem_re = 1'b1;
        end
        else if (cmd.read_item)
        begin
            mem_re    = 1'b1;
            mem_raddr = AW'(cell_index);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            grid_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= grid_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            xc_reg       <= '0;
            yc_reg       <= '0;
            zc_reg       <= '0;
            wr_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg      <= idx_next;
            xc_reg       <= xc_next;
            yc_reg       <= yc_next;
            zc_reg       <= zc_next;
            wr_valid_reg <= wr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            wr_addr_reg <= idx_reg;
            wr_zero_reg <= !copy_ok;
        end
        if (cmd.init)
        begin
            amt_reg <= amt_next;
        end
        if (cmd.load)
        begin
            n_reg[0]   <= sat_mag(shift_x);
            n_reg[1]   <= sat_mag(shift_y);
            n_reg[2]   <= sat_mag(shift_z);
            neg_reg[0] <= shift_x[vgss_pkg::SHIFT_W-1];
            neg_reg[1] <= shift_y[vgss_pkg::SHIFT_W-1];
            neg_reg[2] <= shift_z[vgss_pkg::SHIFT_W-1];
            rd_ok_reg  <= in_range;
        end
        if (cmd.res_read)
        begin
            loaded_reg <= rd_ok_reg & rd_data_reg[0];
            solid_reg  <= rd_ok_reg & rd_data_reg[1];
            regen_reg  <= 1'b0;
        end
        else if (cmd.res_zero || cmd.res_regen)
        begin
            loaded_reg <= 1'b0;
            solid_reg  <= 1'b0;
            regen_reg  <= cmd.res_regen;
        end
    end

    assign loaded_out   = loaded_reg;
    assign solid_out    = solid_reg;
    assign regen_needed = regen_reg;

endmodule

// ===== design/vgss_ctrl.sv =====
// Controller FSM: request accept, clear pass, per-axis sweep sequencing and
// output valid. Depends on vgss_pkg and voxel_grid_scroll_shift_defines.svh.
`include "voxel_grid_scroll_shift_defines.svh"

module vgss_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [vgss_pkg::REQ_W-1:0] req_type,
    output logic                       out_valid,
    input  logic                       out_ready,
    output vgss_pkg::cmd_t             cmd,
    input  vgss_pkg::sts_t             sts
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_AXIS  = 3'd3;
    localparam logic [2:0] S_SWEEP = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic [1:0] phase_inc;

    assign phase_inc = (phase_reg == vgss_pkg::PH_X) ? vgss_pkg::PH_Y : vgss_pkg::PH_Z;
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        cmd.phase  = phase_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.step = 1'b1;
                if (sts.last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    unique case (req_type)
                        vgss_pkg::REQ_WRITE:
                        begin
                            cmd.write_item = 1'b1;
                            cmd.res_zero   = 1'b1;
                        end
                        vgss_pkg::REQ_READ:
                        begin
                            cmd.read_item = 1'b1;
                            state_next    = S_READ;
                        end
                        vgss_pkg::REQ_SCROLL:
                        begin
                            phase_next = vgss_pkg::PH_X;
                            state_next = S_AXIS;
                        end
                        default:
                        begin
                            cmd.res_zero = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                cmd.res_read = 1'b1;
                state_next   = S_IDLE;
            end
            S_AXIS:
            begin
                if (sts.n_zero)
                begin
                    if (phase_reg == vgss_pkg::PH_Z)
                    begin
                        cmd.res_regen = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        phase_next = phase_inc;
                    end
                end
                else
                begin
                    cmd.init   = 1'b1;
                    state_next = S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                cmd.step = 1'b1;
                if (sts.last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (phase_reg == vgss_pkg::PH_CLEAR)
                begin
                    state_next = S_IDLE;
                end
                else if (phase_reg == vgss_pkg::PH_Z)
                begin
                    cmd.res_regen = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    phase_next = phase_inc;
                    state_next = S_AXIS;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.res_read || cmd.res_zero || cmd.res_regen)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            phase_reg     <= vgss_pkg::PH_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `VGSS_ASSERT_NEXT(a_scroll_starts_axis, accept && req_type == vgss_pkg::REQ_SCROLL, state_reg == S_AXIS, "scroll transfer did not start axis walk")
    `VGSS_ASSERT_NOW(a_busy_not_ready, state_reg != S_IDLE, !in_ready, "ready raised while busy")
    `VGSS_ASSERT_NEXT(a_sweep_end_drains, state_reg == S_SWEEP && sts.last, state_reg == S_DRAIN, "sweep end skipped drain")
    `VGSS_ASSERT_NEXT(a_read_responds, state_reg == S_READ, out_valid, "read result not presented")

endmodule

// ===== design/voxel_grid_scroll_shift.sv =====
// Write and unknown requests load the result register when accepted; a read fetches the
// cell, then loads it from S_READ. A scroll walks every grid cell once per nonzero axis.
// Throughput: one write per cycle while the response is not stalled; a read or scroll
// finishes before the next request is taken, so one request at a time. Reset:
// asynchronous active-low; afterwards a clearing pass zeroes the grid with ready held low.
// Top level: joins vgss_ctrl and vgss_datapath; uses vgss_pkg, vgss_req_if, vgss_rsp_if.
module voxel_grid_scroll_shift #(
    parameter int GRID_SIDE = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    vgss_req_if.sink    req_ch,
    vgss_rsp_if.source  rsp_ch
);

    vgss_pkg::cmd_t cmd;
    vgss_pkg::sts_t sts;

    vgss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_ch.valid),
        .in_ready  (req_ch.ready),
        .req_type  (req_ch.req_type),
        .out_valid (rsp_ch.valid),
        .out_ready (rsp_ch.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    vgss_datapath #(
        .GRID_SIDE (GRID_SIDE)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cell_index   (req_ch.cell_index),
        .loaded_in    (req_ch.loaded_in),
        .solid_in     (req_ch.solid_in),
        .shift_x      (req_ch.shift_x),
        .shift_y      (req_ch.shift_y),
        .shift_z      (req_ch.shift_z),
        .loaded_out   (rsp_ch.loaded_out),
        .solid_out    (rsp_ch.solid_out),
        .regen_needed (rsp_ch.regen_needed)
    );

endmodule
